### src/pzmp_pkg.sv
// shared constants, types and helpers for the point zone minimum and pixel projection core
`timescale 1ns / 1ps

package pzmp_pkg;

    // default parameter values
    localparam int unsigned MAX_RANGE_MM = 3000;
    localparam int unsigned COORD_BITS   = 16;

    // fixed field widths
    localparam int unsigned CAM_W     = 16;   // focal lengths and centers, Q12.4
    localparam int unsigned FRAC_BITS = 4;
    localparam int unsigned PIX_W     = 12;
    localparam int unsigned DIST_W    = 12;
    localparam int unsigned SIZE_W    = 13;
    localparam int unsigned LIMIT_W   = 15;
    localparam int unsigned QSHIFT    = FRAC_BITS + PIX_W;
    localparam int unsigned DEPTH_CAP = 4095;

    // serial step counts
    localparam int unsigned MUL_STEPS = CAM_W;
    localparam int unsigned DIV_STEPS = PIX_W;

    // result word layout
    localparam int unsigned OUT_FIELDS_W = 2 * PIX_W + 3 * DIST_W;
    localparam int unsigned OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LIMIT   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_LIMIT   = 4'd7;

    // register reset values
    localparam logic [CAM_W-1:0]   RST_FOCAL_X      = 16'd9600;
    localparam logic [CAM_W-1:0]   RST_FOCAL_Y      = 16'd9600;
    localparam logic [CAM_W-1:0]   RST_CENTER_X     = 16'd5120;
    localparam logic [CAM_W-1:0]   RST_CENTER_Y     = 16'd3840;
    localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [LIMIT_W-1:0] RST_BAND_LIMIT   = 15'd500;
    localparam logic [LIMIT_W-1:0] RST_ZONE_LIMIT   = 15'd300;

    // status of one projection lane
    typedef struct packed {
        logic             done;
        logic             fits;
        logic [PIX_W-1:0] q;
    } lane_status_t;

    // the three zone minima
    typedef struct packed {
        logic [DIST_W-1:0] right;
        logic [DIST_W-1:0] center;
        logic [DIST_W-1:0] left;
    } zone_mins_t;

    // start value of a zone minimum, saturated to the depth field
    function automatic logic [DIST_W-1:0] range_reset(input int unsigned range_mm);
        logic [DIST_W-1:0] r;
        r = (range_mm > DEPTH_CAP) ? DIST_W'(DEPTH_CAP) : DIST_W'(range_mm);
        return r;
    endfunction

endpackage

### src/pzmp_lane.sv
// one projection lane: bit-serial multiply-accumulate and bit-serial rounding divider
`timescale 1ns / 1ps

module pzmp_lane #(
    parameter int unsigned COORD_BITS = pzmp_pkg::COORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [COORD_BITS-1:0]  coord,
    input  logic signed [COORD_BITS-1:0]  depth,
    input  logic [pzmp_pkg::CAM_W-1:0]    focal,
    input  logic [pzmp_pkg::CAM_W-1:0]    center,
    output pzmp_pkg::lane_status_t        status
);

    localparam int unsigned CAM_W  = pzmp_pkg::CAM_W;
    localparam int unsigned PIX_W  = pzmp_pkg::PIX_W;
    localparam int unsigned QSHIFT = pzmp_pkg::QSHIFT;
    localparam int unsigned AW     = COORD_BITS + 2;          // running partial sum
    localparam int unsigned NW     = COORD_BITS + CAM_W + 2;  // full signed product sum
    localparam int unsigned SW     = COORD_BITS + CAM_W + 1;  // rounded magnitude
    localparam int unsigned RW     = COORD_BITS - 1;          // divider remainder
    localparam int unsigned CNT_W  = $clog2(pzmp_pkg::MUL_STEPS);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(pzmp_pkg::MUL_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(pzmp_pkg::DIV_STEPS - 1);

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL,
        L_SUM,
        L_CMP,
        L_DIV,
        L_DONE
    } lane_state_t;

    lane_state_t             state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [AW-1:0]    acc_reg, acc_next;
    logic [CAM_W-1:0]        mult_reg, mult_next;
    logic [CAM_W-1:0]        cen_reg, cen_next;
    logic signed [COORD_BITS-1:0] coord_reg, coord_next;
    logic signed [COORD_BITS-1:0] depth_reg, depth_next;
    logic [SW-1:0]           s_reg, s_next;
    logic                    neg_reg, neg_next;
    logic                    ovf_reg, ovf_next;
    logic [RW-1:0]           rem_reg, rem_next;
    logic [PIX_W-1:0]        quo_reg, quo_next;

    logic signed [AW-1:0]    add_c, add_d, psum;
    logic [NW-1:0]           prod, z8, sval;
    logic [SW-1:0]           ovf_lim;
    logic [COORD_BITS-1:0]   trial, dz, diff;
    logic                    ge;

    // multiply step: focal bit picks the coordinate, center bit picks the depth
    assign add_c = mult_reg[0] ? AW'(coord_reg) : AW'(0);
    assign add_d = cen_reg[0] ? AW'(depth_reg) : AW'(0);
    assign psum  = acc_reg + add_c + add_d;

    // magnitude plus half divisor: |n| + 8z, n negative turns into 8z - n
    assign prod = {acc_reg, mult_reg};
    assign z8   = NW'({depth_reg, 3'b000});
    assign sval = acc_reg[AW-1] ? (z8 - prod) : (prod + z8);

    // quotient of 4096 or more never lands in the image
    assign ovf_lim = SW'({depth_reg, {QSHIFT{1'b0}}});

    // restoring divide step, one quotient bit
    assign trial = {rem_reg, quo_reg[PIX_W-1]};
    assign dz    = $unsigned(depth_reg);
    assign ge    = trial >= dz;
    assign diff  = trial - dz;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mult_next  = mult_reg;
        cen_next   = cen_reg;
        coord_next = coord_reg;
        depth_next = depth_reg;
        s_next     = s_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            state_next = L_MUL;
            cnt_next   = '0;
            acc_next   = '0;
            mult_next  = focal;
            cen_next   = center;
            coord_next = coord;
            depth_next = depth;
        end
        else
        begin
            unique case (state_reg)
                L_IDLE, L_DONE:
                begin
                end
                L_MUL:
                begin
                    acc_next  = psum >>> 1;
                    mult_next = {psum[0], mult_reg[CAM_W-1:1]};
                    cen_next  = cen_reg >> 1;
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg == MUL_LAST)
                    begin
                        cnt_next   = '0;
                        state_next = L_SUM;
                    end
                end
                L_SUM:
                begin
                    neg_next   = acc_reg[AW-1];
                    s_next     = sval[SW-1:0];
                    state_next = L_CMP;
                end
                L_CMP:
                begin
                    ovf_next   = s_reg >= ovf_lim;
                    rem_next   = s_reg[QSHIFT+RW-1:QSHIFT];
                    quo_next   = s_reg[QSHIFT-1 -: PIX_W];
                    state_next = (s_reg >= ovf_lim) ? L_DONE : L_DIV;
                end
                L_DIV:
                begin
                    rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
                    quo_next = {quo_reg[PIX_W-2:0], ge};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        cnt_next   = '0;
                        state_next = L_DONE;
                    end
                end
                default:
                begin
                    state_next = L_IDLE;
                end
            endcase
        end
    end

    // lane sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            mult_reg  <= '0;
            cen_reg   <= '0;
            coord_reg <= '0;
            depth_reg <= '0;
            s_reg     <= '0;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            rem_reg   <= '0;
            quo_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            mult_reg  <= mult_next;
            cen_reg   <= cen_next;
            coord_reg <= coord_next;
            depth_reg <= depth_next;
            s_reg     <= s_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
        end
    end

    // a negative result lands in the image only when it rounds to zero
    assign status.done = (state_reg == L_DONE);
    assign status.fits = !ovf_reg && (!neg_reg || (quo_reg == '0));
    assign status.q    = quo_reg;

endmodule

### src/pzmp_zone.sv
// per-zone least depth tracker with snapshot on the last point of a cloud
`timescale 1ns / 1ps

module pzmp_zone #(
    parameter int unsigned COORD_BITS   = pzmp_pkg::COORD_BITS,
    parameter int unsigned MAX_RANGE_MM = pzmp_pkg::MAX_RANGE_MM
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           update,
    input  logic signed [COORD_BITS-1:0]   point_x,
    input  logic signed [COORD_BITS-1:0]   point_y,
    input  logic signed [COORD_BITS-1:0]   point_z,
    input  logic                           depth_finite,
    input  logic                           last_point,
    input  logic [pzmp_pkg::LIMIT_W-1:0]   band_limit,
    input  logic [pzmp_pkg::LIMIT_W-1:0]   zone_limit,
    output pzmp_pkg::zone_mins_t           snapshot
);

    localparam int unsigned DIST_W = pzmp_pkg::DIST_W;
    localparam int unsigned CW =
        ((COORD_BITS > pzmp_pkg::LIMIT_W) ? COORD_BITS : pzmp_pkg::LIMIT_W) + 2;
    localparam logic [DIST_W-1:0] RANGE_RESET = pzmp_pkg::range_reset(MAX_RANGE_MM);

    pzmp_pkg::zone_mins_t mins_reg, mins_next, snap_reg;
    logic signed [CW-1:0] xs, ys, zs, band_s, zone_s, cap_s;
    logic [DIST_W-1:0]    depth_sat;
    logic                 in_band;

    // widen to a common signed compare width
    assign xs     = CW'(point_x);
    assign ys     = CW'(point_y);
    assign zs     = CW'(point_z);
    assign band_s = $signed(CW'(band_limit));
    assign zone_s = $signed(CW'(zone_limit));
    assign cap_s  = $signed(CW'(pzmp_pkg::DEPTH_CAP));

    assign in_band   = (ys > -band_s) && (ys < band_s);
    assign depth_sat = (zs < 0) ? '0 :
                       ((zs > cap_s) ? DIST_W'(pzmp_pkg::DEPTH_CAP) : zs[DIST_W-1:0]);

    // pick the zone by lateral position and keep the smaller depth
    always_comb
    begin
        mins_next = mins_reg;
        if (depth_finite && in_band)
        begin
            priority if (xs < -zone_s)
            begin
                if (depth_sat < mins_reg.left)
                    mins_next.left = depth_sat;
            end
            else if (xs > zone_s)
            begin
                if (depth_sat < mins_reg.right)
                    mins_next.right = depth_sat;
            end
            else
            begin
                if (depth_sat < mins_reg.center)
                    mins_next.center = depth_sat;
            end
        end
    end

    // running minima, restarted after the last point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mins_reg <= '{right: RANGE_RESET, center: RANGE_RESET, left: RANGE_RESET};
        end
        else if (update)
        begin
            if (last_point)
                mins_reg <= '{right: RANGE_RESET, center: RANGE_RESET, left: RANGE_RESET};
            else
                mins_reg <= mins_next;
        end
    end

    // minima including the last point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_reg <= '0;
        else if (update && last_point)
            snap_reg <= mins_next;
    end

    assign snapshot = snap_reg;

endmodule

### src/point_zone_min_and_pixel_project_core.sv
// top level: stream ports, configuration registers, sequencer and result register
`timescale 1ns / 1ps
// a finite point with positive depth runs in both lanes: the 16-step serial multiply,
//   then the 12-step serial divide, skipped in a lane whose quotient reaches 4096;
//   any other point goes straight to the result stage; the input is ready again only
//   once the result word is loaded, which waits while an earlier word is stalled
// reset: rst_n clears control state at once, restores register defaults and zone minima

module point_zone_min_and_pixel_project_core #(
    parameter int unsigned COORD_BITS   = pzmp_pkg::COORD_BITS,
    parameter int unsigned MAX_RANGE_MM = pzmp_pkg::MAX_RANGE_MM,
    localparam int unsigned IN_W        = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [IN_W-1:0]                     s_tdata,   // point_x, point_y, point_z, zero pad
    input  logic [0:0]                          s_tuser,   // depth_finite
    input  logic                                s_tlast,   // last_point
    // result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pzmp_pkg::OUT_W-1:0]          m_tdata,   // pixel_u, pixel_v, nearest_left,
                                                           // nearest_center, nearest_right, pad
    output logic [0:0]                          m_tuser,   // in_image
    output logic                                m_tlast,   // distances_ready
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pzmp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pzmp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned CAM_W   = pzmp_pkg::CAM_W;
    localparam int unsigned PIX_W   = pzmp_pkg::PIX_W;
    localparam int unsigned SIZE_W  = pzmp_pkg::SIZE_W;
    localparam int unsigned LIMIT_W = pzmp_pkg::LIMIT_W;
    localparam int unsigned PAD_W   = pzmp_pkg::OUT_W - pzmp_pkg::OUT_FIELDS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } core_state_t;

    // configuration registers
    logic [CAM_W-1:0]   focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [SIZE_W-1:0]  image_width_reg, image_height_reg;
    logic [LIMIT_W-1:0] band_limit_reg, zone_limit_reg;

    // sequencer and result registers
    core_state_t          state_reg, state_next;
    logic                 last_reg, last_next;
    logic                 proj_reg, proj_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [PIX_W-1:0]     pixel_u_reg, pixel_u_next;
    logic [PIX_W-1:0]     pixel_v_reg, pixel_v_next;
    logic                 in_image_reg, in_image_next;
    logic                 ready_reg, ready_next;
    pzmp_pkg::zone_mins_t near_reg, near_next;

    logic signed [COORD_BITS-1:0] x_in, y_in, z_in;
    logic                 accept, proj_in, start, load_out, u_in, v_in, pix_ok;
    pzmp_pkg::lane_status_t lane_u, lane_v;
    pzmp_pkg::zone_mins_t   snapshot;

    // unpack the input word
    assign x_in    = $signed(s_tdata[COORD_BITS-1:0]);
    assign y_in    = $signed(s_tdata[2*COORD_BITS-1:COORD_BITS]);
    assign z_in    = $signed(s_tdata[3*COORD_BITS-1:2*COORD_BITS]);
    assign accept  = s_tvalid && s_tready;
    assign proj_in = s_tuser[0] && !z_in[COORD_BITS-1] && (z_in != '0);
    assign start   = accept && proj_in;

    pzmp_lane #(
        .COORD_BITS (COORD_BITS)
    ) u_lane_u (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .coord  (x_in),
        .depth  (z_in),
        .focal  (focal_x_reg),
        .center (center_x_reg),
        .status (lane_u)
    );

    pzmp_lane #(
        .COORD_BITS (COORD_BITS)
    ) u_lane_v (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .coord  (y_in),
        .depth  (z_in),
        .focal  (focal_y_reg),
        .center (center_y_reg),
        .status (lane_v)
    );

    pzmp_zone #(
        .COORD_BITS   (COORD_BITS),
        .MAX_RANGE_MM (MAX_RANGE_MM)
    ) u_zone (
        .clk          (clk),
        .rst_n        (rst_n),
        .update       (accept),
        .point_x      (x_in),
        .point_y      (y_in),
        .point_z      (z_in),
        .depth_finite (s_tuser[0]),
        .last_point   (s_tlast),
        .band_limit   (band_limit_reg),
        .zone_limit   (zone_limit_reg),
        .snapshot     (snapshot)
    );

    // configuration writes, unknown indexes dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg      <= pzmp_pkg::RST_FOCAL_X;
            focal_y_reg      <= pzmp_pkg::RST_FOCAL_Y;
            center_x_reg     <= pzmp_pkg::RST_CENTER_X;
            center_y_reg     <= pzmp_pkg::RST_CENTER_Y;
            image_width_reg  <= pzmp_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= pzmp_pkg::RST_IMAGE_HEIGHT;
            band_limit_reg   <= pzmp_pkg::RST_BAND_LIMIT;
            zone_limit_reg   <= pzmp_pkg::RST_ZONE_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pzmp_pkg::REG_FOCAL_X:      focal_x_reg      <= cfg_data;
                pzmp_pkg::REG_FOCAL_Y:      focal_y_reg      <= cfg_data;
                pzmp_pkg::REG_CENTER_X:     center_x_reg     <= cfg_data;
                pzmp_pkg::REG_CENTER_Y:     center_y_reg     <= cfg_data;
                pzmp_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[SIZE_W-1:0];
                pzmp_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[SIZE_W-1:0];
                pzmp_pkg::REG_BAND_LIMIT:   band_limit_reg   <= cfg_data[LIMIT_W-1:0];
                pzmp_pkg::REG_ZONE_LIMIT:   zone_limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // bounds test; lane quotients are below 4096 so wider sizes act as 4096
    assign u_in   = lane_u.fits && ({1'b0, lane_u.q} < image_width_reg);
    assign v_in   = lane_v.fits && ({1'b0, lane_v.q} < image_height_reg);
    assign pix_ok = proj_reg && u_in && v_in;

    assign load_out = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // sequencer and result register
    always_comb
    begin
        state_next    = state_reg;
        last_next     = last_reg;
        proj_next     = proj_reg;
        m_tvalid_next = m_tvalid_reg;
        pixel_u_next  = pixel_u_reg;
        pixel_v_next  = pixel_v_reg;
        in_image_next = in_image_reg;
        ready_next    = ready_reg;
        near_next     = near_reg;
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next  = s_tlast;
                    proj_next  = proj_in;
                    state_next = proj_in ? S_RUN : S_DONE;
                end
            end
            S_RUN:
            begin
                if (lane_u.done && lane_v.done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    m_tvalid_next = 1'b1;
                    pixel_u_next  = pix_ok ? lane_u.q : '0;
                    pixel_v_next  = pix_ok ? lane_v.q : '0;
                    in_image_next = pix_ok;
                    ready_next    = last_reg;
                    near_next     = last_reg ? snapshot : '0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            last_reg     <= 1'b0;
            proj_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            pixel_u_reg  <= '0;
            pixel_v_reg  <= '0;
            in_image_reg <= 1'b0;
            ready_reg    <= 1'b0;
            near_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            last_reg     <= last_next;
            proj_reg     <= proj_next;
            m_tvalid_reg <= m_tvalid_next;
            pixel_u_reg  <= pixel_u_next;
            pixel_v_reg  <= pixel_v_next;
            in_image_reg <= in_image_next;
            ready_reg    <= ready_next;
            near_reg     <= near_next;
        end
    end

    // port drive
    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {{PAD_W{1'b0}}, near_reg.right, near_reg.center, near_reg.left,
                         pixel_v_reg, pixel_u_reg};
    assign m_tuser[0] = in_image_reg;
    assign m_tlast    = ready_reg;

`ifndef ASSERT_OFF
    // a stalled result word holds still until taken
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("result word changed while stalled");

    // an in-image pixel lies inside the configured image
    a_pixel_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |->
            (({1'b0, pixel_u_reg} < image_width_reg) &&
             ({1'b0, pixel_v_reg} < image_height_reg)))
        else $error("in-image pixel outside image bounds");

    // pixel fields are zero when the point is not in the image
    a_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> ((pixel_u_reg == '0) && (pixel_v_reg == '0)))
        else $error("pixel fields set on a point outside the image");

    // reported minima never exceed the start range, and are zero off the last point
    a_near_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            (m_tlast ? ((near_reg.left <= pzmp_pkg::range_reset(MAX_RANGE_MM)) &&
                        (near_reg.center <= pzmp_pkg::range_reset(MAX_RANGE_MM)) &&
                        (near_reg.right <= pzmp_pkg::range_reset(MAX_RANGE_MM)))
                     : (near_reg == '0)))
        else $error("zone minimum out of range");
`endif

endmodule

### bench/testbench.sv
// testbench for the point zone minimum and pixel projection core
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned COORD_BITS    = pzmp_pkg::COORD_BITS;
    localparam int unsigned MAX_RANGE_MM  = pzmp_pkg::MAX_RANGE_MM;
    localparam int unsigned DEPTH_CAP     = pzmp_pkg::DEPTH_CAP;
    localparam int unsigned PIX_W         = pzmp_pkg::PIX_W;
    localparam int unsigned DIST_W        = pzmp_pkg::DIST_W;
    localparam int unsigned OUT_W         = pzmp_pkg::OUT_W;
    localparam int unsigned CAM_W         = pzmp_pkg::CAM_W;
    localparam int unsigned SIZE_W        = pzmp_pkg::SIZE_W;
    localparam int unsigned LIMIT_W       = pzmp_pkg::LIMIT_W;
    localparam int unsigned CFG_IDX_W     = pzmp_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W    = pzmp_pkg::CFG_DATA_W;
    localparam int unsigned IN_W          = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int unsigned REG_COUNT     = 8;
    localparam longint      IMG_CAP       = 4096;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam longint      COORD_MAX     = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint      COORD_MIN     = -COORD_MAX - 1;
    localparam logic [DIST_W-1:0] RANGE_START =
        (MAX_RANGE_MM > DEPTH_CAP) ? DIST_W'(DEPTH_CAP) : DIST_W'(MAX_RANGE_MM);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // one expected result word
    typedef struct packed {
        logic [PIX_W-1:0]  u;
        logic [PIX_W-1:0]  v;
        logic              hit;
        logic [DIST_W-1:0] left;
        logic [DIST_W-1:0] center;
        logic [DIST_W-1:0] right;
        logic              ready;
    } projection_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor copy of the registers and zone minima
    logic [CAM_W-1:0]   cam_fx      = pzmp_pkg::RST_FOCAL_X;
    logic [CAM_W-1:0]   cam_fy      = pzmp_pkg::RST_FOCAL_Y;
    logic [CAM_W-1:0]   cam_cx      = pzmp_pkg::RST_CENTER_X;
    logic [CAM_W-1:0]   cam_cy      = pzmp_pkg::RST_CENTER_Y;
    logic [SIZE_W-1:0]  img_w       = pzmp_pkg::RST_IMAGE_WIDTH;
    logic [SIZE_W-1:0]  img_h       = pzmp_pkg::RST_IMAGE_HEIGHT;
    logic [LIMIT_W-1:0] band_mm     = pzmp_pkg::RST_BAND_LIMIT;
    logic [LIMIT_W-1:0] zone_mm     = pzmp_pkg::RST_ZONE_LIMIT;
    logic [DIST_W-1:0]  near_left   = RANGE_START;
    logic [DIST_W-1:0]  near_center = RANGE_START;
    logic [DIST_W-1:0]  near_right  = RANGE_START;

    projection_t pending_projections[$];
    int unsigned errors      = 0;
    int unsigned idle_cycles = 0;
    logic        calm        = 1'b0;

    point_zone_min_and_pixel_project_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // round n/d to nearest, halves away from zero, d > 0
    function automatic longint round_half_away(longint n, longint d);
        if (n >= 0)
            return (2 * n + d) / (2 * d);
        return -((-2 * n + d) / (2 * d));
    endfunction

    function automatic coord_t clamp_coord(longint v);
        if (v > COORD_MAX)
            return coord_t'(COORD_MAX);
        if (v < COORD_MIN)
            return coord_t'(COORD_MIN);
        return coord_t'(v);
    endfunction

    function automatic longint capped_size(logic [SIZE_W-1:0] s);
        return (longint'(s) > IMG_CAP) ? IMG_CAP : longint'(s);
    endfunction

    // register write as seen by the predictor, masked to each width
    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            pzmp_pkg::REG_FOCAL_X:      cam_fx  = data;
            pzmp_pkg::REG_FOCAL_Y:      cam_fy  = data;
            pzmp_pkg::REG_CENTER_X:     cam_cx  = data;
            pzmp_pkg::REG_CENTER_Y:     cam_cy  = data;
            pzmp_pkg::REG_IMAGE_WIDTH:  img_w   = data[SIZE_W-1:0];
            pzmp_pkg::REG_IMAGE_HEIGHT: img_h   = data[SIZE_W-1:0];
            pzmp_pkg::REG_BAND_LIMIT:   band_mm = data[LIMIT_W-1:0];
            pzmp_pkg::REG_ZONE_LIMIT:   zone_mm = data[LIMIT_W-1:0];
            default:                    ;
        endcase
    endfunction

    // zone update and pinhole projection of one point
    function automatic projection_t project_point(coord_t x, coord_t y, coord_t z,
                                                  logic finite, logic last);
        projection_t       r;
        longint            lx, ly, lz, u, v;
        logic [DIST_W-1:0] d;
        r  = '0;
        lx = x;
        ly = y;
        lz = z;
        if (finite)
        begin
            // zone sort inside the vertical band
            if (ly > -longint'(band_mm) && ly < longint'(band_mm))
            begin
                if (lz < 0)
                    d = '0;
                else if (lz > longint'(DEPTH_CAP))
                    d = DIST_W'(DEPTH_CAP);
                else
                    d = DIST_W'(lz);
                if (lx < -longint'(zone_mm))
                begin
                    if (d < near_left)
                        near_left = d;
                end
                else if (lx > longint'(zone_mm))
                begin
                    if (d < near_right)
                        near_right = d;
                end
                else if (d < near_center)
                    near_center = d;
            end
            // projection for positive depth only
            if (lz > 0)
            begin
                u = round_half_away(longint'(cam_fx) * lx + longint'(cam_cx) * lz, 16 * lz);
                v = round_half_away(longint'(cam_fy) * ly + longint'(cam_cy) * lz, 16 * lz);
                if (u >= 0 && u < capped_size(img_w) && v >= 0 && v < capped_size(img_h))
                begin
                    r.u   = PIX_W'(u);
                    r.v   = PIX_W'(v);
                    r.hit = 1'b1;
                end
            end
        end
        // hand out the minima on the last point of a cloud
        if (last)
        begin
            r.left      = near_left;
            r.center    = near_center;
            r.right     = near_right;
            r.ready     = 1'b1;
            near_left   = RANGE_START;
            near_center = RANGE_START;
            near_right  = RANGE_START;
        end
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            errors++;
        end
    endfunction

    // receiver stalls
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= 33);

    // result checker
    always @(posedge clk)
    begin : check_results
        projection_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_projections.size() == 0)
            begin
                $error("result word with no point pending");
                errors++;
            end
            else
            begin
                want = pending_projections.pop_front();
                check_field("pixel_u", want.u, m_tdata[PIX_W-1:0]);
                check_field("pixel_v", want.v, m_tdata[2*PIX_W-1:PIX_W]);
                check_field("in_image", want.hit, m_tuser[0]);
                check_field("nearest_left", want.left, m_tdata[2*PIX_W+DIST_W-1:2*PIX_W]);
                check_field("nearest_center", want.center,
                            m_tdata[2*PIX_W+2*DIST_W-1:2*PIX_W+DIST_W]);
                check_field("nearest_right", want.right,
                            m_tdata[2*PIX_W+3*DIST_W-1:2*PIX_W+2*DIST_W]);
                check_field("distances_ready", want.ready, m_tlast);
            end
        end
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // send one point word, with an occasional gap before it
    task automatic send_point(coord_t x, coord_t y, coord_t z, logic finite, logic last);
        projection_t want;
        if (!calm && $urandom_range(0, 99) < 33)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 36)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({z, y, x});
        s_tuser  <= finite;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        want = project_point(x, y, z, finite, last);
        pending_projections.insert(pending_projections.size(), want);
    endtask

    // stop sending and wait until every result is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_projections.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one register write, valid left high for back-to-back writes
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, data);
    endtask

    // full register set plus one write to an unused index
    task automatic load_camera(logic [15:0] fx, logic [15:0] fy, logic [15:0] cx,
                               logic [15:0] cy, logic [15:0] w, logic [15:0] h,
                               logic [15:0] band, logic [15:0] zone);
        write_reg(pzmp_pkg::REG_FOCAL_X, fx);
        write_reg(pzmp_pkg::REG_FOCAL_Y, fy);
        write_reg(pzmp_pkg::REG_CENTER_X, cx);
        write_reg(pzmp_pkg::REG_CENTER_Y, cy);
        write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_COUNT)),
                  CFG_DATA_W'($urandom));
        write_reg(pzmp_pkg::REG_IMAGE_WIDTH, w);
        write_reg(pzmp_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(pzmp_pkg::REG_BAND_LIMIT, band);
        write_reg(pzmp_pkg::REG_ZONE_LIMIT, zone);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // reset settings: zones, band and zone edges, depth specials, image corners
    task automatic test_default_camera();
        send_point(0, 0, 1000, 1, 0);
        send_point(-301, 0, 800, 1, 0);
        send_point(301, 0, 900, 1, 0);
        send_point(-300, 0, 700, 1, 0);
        send_point(300, 499, 650, 1, 0);
        send_point(0, 500, 10, 1, 0);
        send_point(0, -500, 10, 1, 0);
        send_point(0, -499, -5, 1, 0);
        send_point(0, 0, 0, 1, 0);
        send_point(100, 100, 32767, 1, 0);
        send_point(-32768, -32768, -32768, 1, 0);
        send_point(32767, 32767, 32767, 1, 0);
        send_point(0, 0, 100, 0, 1);
        send_point(0, 0, 0, 0, 1);
        send_point(-400, 0, 100, 1, 1);
        send_point(-320, -240, 600, 1, 0);
        send_point(319, 239, 600, 1, 0);
        send_point(320, 240, 600, 1, 0);
        send_point(2, 0, 32, 1, 0);
        send_point(-2, 0, 32, 1, 1);
        wait_idle();
    endtask

    // registers at their limits, oversized and zero image sizes
    task automatic test_register_extremes();
        load_camera(16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_point(0, 0, 1, 1, 0);
        send_point(-5, 0, 20, 1, 0);
        send_point(7, -1, 3, 1, 1);
        wait_idle();

        load_camera(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd4096,
                    16'hFFFF, 16'hFFFF);
        send_point(-100, -100, 32767, 1, 0);
        send_point(-1, -1, 32767, 1, 0);
        send_point(-32768, -32768, 32767, 1, 0);
        send_point(-32768, 0, 5, 1, 0);
        send_point(32767, 0, 6, 1, 0);
        send_point(0, 32767, 2, 1, 1);
        wait_idle();

        load_camera(16'd1, 16'd1, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd0);
        send_point(0, 0, 1, 1, 0);
        send_point(1, 0, 2, 1, 0);
        send_point(-1, 0, 3, 1, 0);
        send_point(7, 7, 1, 1, 1);
        wait_idle();
    endtask

    // random camera: half of the time a plausible one, else any bits but a zero focal length
    task automatic configure_random();
        int unsigned w, h;
        if ($urandom_range(0, 1) == 1)
        begin
            w = $urandom_range(16, 4096);
            h = $urandom_range(16, 4096);
            load_camera(16'($urandom_range(2000, 20000)), 16'($urandom_range(2000, 20000)),
                        16'($urandom_range(w * 4, w * 12 > 65535 ? 65535 : w * 12)),
                        16'($urandom_range(h * 4, h * 12 > 65535 ? 65535 : h * 12)),
                        16'(w), 16'(h), 16'($urandom_range(0, 3000)),
                        16'($urandom_range(0, 2000)));
        end
        else
            load_camera(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                        16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
    endtask

    // mostly plausible points, some aimed into the image, some pure noise
    task automatic send_random_point(logic last);
        coord_t      x, y, z;
        logic        finite;
        int unsigned mode;
        longint      lz, w, h, span;
        mode = $urandom_range(0, 99);
        if (mode < 15)
        begin
            x      = coord_t'($urandom);
            y      = coord_t'($urandom);
            z      = coord_t'($urandom);
            finite = 1'($urandom_range(0, 1));
        end
        else
        begin
            finite = ($urandom_range(0, 99) >= 5);
            if ($urandom_range(0, 99) < 8)
                lz = -longint'($urandom_range(0, 32768));
            else
                lz = longint'($urandom_range(1, 4600));
            z = clamp_coord(lz);
            if (mode < 60)
            begin
                // aim at a random pixel inside the image
                w = capped_size(img_w);
                h = capped_size(img_h);
                w = (w == 0) ? 1 : w;
                h = (h == 0) ? 1 : h;
                x = clamp_coord(((longint'($urandom_range(0, w - 1)) * 16 - longint'(cam_cx))
                                 * lz) / longint'(cam_fx));
                y = clamp_coord(((longint'($urandom_range(0, h - 1)) * 16 - longint'(cam_cy))
                                 * lz) / longint'(cam_fy));
            end
            else
            begin
                // spread around the zone and band edges
                span = 1000;
                if ($urandom_range(0, 99) < 20)
                    x = clamp_coord(($urandom_range(0, 1) ? 1 : -1)
                                    * (longint'(zone_mm) + $urandom_range(0, 1)));
                else
                    x = clamp_coord(longint'($urandom_range(0, 2 * (zone_mm + span)))
                                    - (longint'(zone_mm) + span));
                if ($urandom_range(0, 99) < 20)
                    y = clamp_coord(($urandom_range(0, 1) ? 1 : -1)
                                    * (longint'(band_mm) - $urandom_range(0, 1)));
                else
                    y = clamp_coord(longint'($urandom_range(0, 2 * (band_mm + span)))
                                    - (longint'(band_mm) + span));
            end
        end
        send_point(x, y, z, finite, last);
    endtask

    // random clouds over several camera settings, one phase without idling
    task automatic test_random_clouds();
        int unsigned sent, len;
        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase == 0)
                load_camera(pzmp_pkg::RST_FOCAL_X, pzmp_pkg::RST_FOCAL_Y,
                            pzmp_pkg::RST_CENTER_X, pzmp_pkg::RST_CENTER_Y,
                            16'(pzmp_pkg::RST_IMAGE_WIDTH), 16'(pzmp_pkg::RST_IMAGE_HEIGHT),
                            16'(pzmp_pkg::RST_BAND_LIMIT), 16'(pzmp_pkg::RST_ZONE_LIMIT));
            else
                configure_random();
            calm = (phase == 2);
            sent = 0;
            while (sent < 80)
            begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                    send_random_point(k == len - 1);
                sent += len;
            end
            wait_idle();
        end
        calm = 1'b0;
    endtask

    // test sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_camera();
        test_register_extremes();
        test_random_clouds();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending_projections.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
